// ----- rtl/stt_pkg.sv -----
// Shared types and codes for the software timer table.
// No dependencies; used by stt_slot and software_timer_table.
package stt_pkg;

    typedef enum logic [2:0] {
        CMD_FAST_TICK = 3'd0,
        CMD_SLOW_TICK = 3'd1,
        CMD_CREATE    = 3'd2,
        CMD_START     = 3'd3,
        CMD_STOP      = 3'd4,
        CMD_DESTROY   = 3'd5
    } cmd_t;

    localparam int unsigned INTERVAL_W = 32;
    localparam int unsigned MASK_W     = 8;
    localparam int unsigned SLOT_W     = 3;

    // Per-slot command strobes; start, stop and destroy are already qualified by the slot address
    typedef struct packed {
        logic tick;
        logic tick_fast;
        logic create;
        logic start;
        logic stop;
        logic destroy;
        logic fast;
        logic periodic;
    } slot_cmd_t;

endpackage

// ----- rtl/stt_slot.sv -----
// One timer slot: mode bits, interval and countdown.
// Depends on stt_pkg for the slot command struct.
module stt_slot
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  stt_pkg::slot_cmd_t                   cmd,
    input  logic [stt_pkg::INTERVAL_W-1:0]       interval,
    output logic                                 used,
    output logic                                 fire
);

    logic                              used_reg, used_next;
    logic                              fast_reg, fast_next;
    logic                              periodic_reg, periodic_next;
    logic                              live_reg, live_next;
    logic                              running_reg, running_next;
    logic [stt_pkg::INTERVAL_W-1:0]    period_reg, period_next;
    logic [stt_pkg::INTERVAL_W-1:0]    remaining_reg, remaining_next;
    logic [stt_pkg::INTERVAL_W-1:0]    remaining_dec;
    logic                              counting;

    assign remaining_dec = remaining_reg - stt_pkg::INTERVAL_W'(1);
    assign counting = cmd.tick && used_reg && running_reg && live_reg
                      && (fast_reg == cmd.tick_fast) && (period_reg != '0);

    always_comb
    begin
        used_next      = used_reg;
        fast_next      = fast_reg;
        periodic_next  = periodic_reg;
        live_next      = live_reg;
        running_next   = running_reg;
        period_next    = period_reg;
        remaining_next = remaining_reg;
        fire           = 1'b0;
        if (counting)
        begin
            remaining_next = remaining_dec;
            if (remaining_dec == '0)
            begin
                // expire: reload, and a one-shot goes dead
                fire           = 1'b1;
                remaining_next = period_reg;
                if (!periodic_reg)
                begin
                    live_next = 1'b0;
                end
            end
        end
        else if (cmd.create)
        begin
            used_next      = 1'b1;
            fast_next      = cmd.fast;
            periodic_next  = cmd.periodic;
            live_next      = 1'b1;
            running_next   = 1'b0;
            period_next    = interval;
            remaining_next = '0;
        end
        else if (cmd.start && used_reg)
        begin
            running_next   = 1'b1;
            remaining_next = period_reg;
        end
        else if (cmd.stop && used_reg)
        begin
            running_next = 1'b0;
        end
        else if (cmd.destroy && used_reg)
        begin
            used_next      = 1'b0;
            fast_next      = 1'b0;
            periodic_next  = 1'b0;
            live_next      = 1'b0;
            running_next   = 1'b0;
            period_next    = '0;
            remaining_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= 1'b0;
            fast_reg      <= 1'b0;
            periodic_reg  <= 1'b0;
            live_reg      <= 1'b0;
            running_reg   <= 1'b0;
            period_reg    <= '0;
            remaining_reg <= '0;
        end
        else
        begin
            used_reg      <= used_next;
            fast_reg      <= fast_next;
            periodic_reg  <= periodic_next;
            live_reg      <= live_next;
            running_reg   <= running_next;
            period_reg    <= period_next;
            remaining_reg <= remaining_next;
        end
    end

    assign used = used_reg;

endmodule

// ----- rtl/stt_alloc.sv -----
// Lowest-free-slot finder for create requests.
// No package dependencies.
module stt_alloc
#(
    parameter int SLOTS = 8,
    parameter int IDX_W = 3
)
(
    input  logic [SLOTS-1:0] free,
    output logic             found,
    output logic [IDX_W-1:0] index
);

    always_comb
    begin
        found = 1'b0;
        index = '0;
        // scan downward so the lowest free slot wins
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if (free[k])
            begin
                found = 1'b1;
                index = IDX_W'(k);
            end
        end
    end

endmodule

// ----- rtl/software_timer_table.sv -----
// Top level of the software timer table: request register, slot array, result register.
// Depends on stt_pkg, stt_slot and stt_alloc.
//
// A table of SLOTS timer slots counted by a fast and a slow tick. Each request
// (tick, create, start, stop, destroy) is taken into a request register and
// resolved against the slot flip-flops, all slots updating in parallel, into
// a result register: one request per cycle while out_stall does not hold the
// result register. Every request gives exactly one result.
// Only slots 0 to 7 can be addressed and reported in fire_mask; new_slot holds
// the low three bits of the slot index taken by create.
module software_timer_table
#(
    parameter int SLOTS = 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0]                         command,
    input  logic [stt_pkg::SLOT_W-1:0]         slot,
    input  logic                               fast_source,
    input  logic                               periodic,
    input  logic [stt_pkg::INTERVAL_W-1:0]     interval,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [stt_pkg::MASK_W-1:0]         fire_mask,
    output logic                               created,
    output logic [stt_pkg::SLOT_W-1:0]         new_slot
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // request register
    logic                               req_valid_reg, req_valid_next;
    logic [2:0]                         command_reg;
    logic [stt_pkg::SLOT_W-1:0]         slot_reg;
    logic                               fast_reg;
    logic                               periodic_reg;
    logic [stt_pkg::INTERVAL_W-1:0]     interval_reg;

    // result register
    logic                               out_valid_reg, out_valid_next;
    logic [stt_pkg::MASK_W-1:0]         fire_mask_reg;
    logic                               created_reg;
    logic [stt_pkg::SLOT_W-1:0]         new_slot_reg;

    logic                               accept;
    logic                               advance;
    logic                               res_ready;

    logic                               is_tick, is_fast, is_create;
    logic                               is_start, is_stop, is_destroy;

    logic [SLOTS-1:0]                   used;
    logic [SLOTS-1:0]                   fire;
    logic [SLOTS-1:0]                   hit;
    logic                               found;
    logic [IDX_W-1:0]                   free_idx;
    logic [IDX_W+2:0]                   free_idx_wide;
    logic [stt_pkg::MASK_W-1:0]         mask;

    assign res_ready = !out_valid_reg || !out_stall;
    assign advance   = req_valid_reg && res_ready;
    assign in_stall  = req_valid_reg && !res_ready;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        is_tick    = 1'b0;
        is_fast    = 1'b0;
        is_create  = 1'b0;
        is_start   = 1'b0;
        is_stop    = 1'b0;
        is_destroy = 1'b0;
        unique case (command_reg)
            stt_pkg::CMD_FAST_TICK:
            begin
                is_tick = 1'b1;
                is_fast = 1'b1;
            end
            stt_pkg::CMD_SLOW_TICK: is_tick    = 1'b1;
            stt_pkg::CMD_CREATE:    is_create  = 1'b1;
            stt_pkg::CMD_START:     is_start   = 1'b1;
            stt_pkg::CMD_STOP:      is_stop    = 1'b1;
            stt_pkg::CMD_DESTROY:   is_destroy = 1'b1;
            default:                is_tick    = 1'b0;
        endcase
    end

    stt_alloc
    #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    )
    u_alloc
    (
        .free  (~used),
        .found (found),
        .index (free_idx)
    );

    genvar k;
    generate
        for (k = 0; k < SLOTS; k++)
        begin : g_slot
            stt_pkg::slot_cmd_t cmd;

            if (k < stt_pkg::MASK_W)
            begin : g_addr
                assign hit[k] = (slot_reg == stt_pkg::SLOT_W'(k));
            end
            else
            begin : g_noaddr
                assign hit[k] = 1'b0;
            end

            assign cmd.tick      = advance && is_tick;
            assign cmd.tick_fast = is_fast;
            assign cmd.create    = advance && is_create && found
                                   && (free_idx == IDX_W'(k));
            assign cmd.start     = advance && is_start && hit[k];
            assign cmd.stop      = advance && is_stop && hit[k];
            assign cmd.destroy   = advance && is_destroy && hit[k];
            assign cmd.fast      = fast_reg;
            assign cmd.periodic  = periodic_reg;

            stt_slot u_slot
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .interval (interval_reg),
                .used     (used[k]),
                .fire     (fire[k])
            );
        end

        for (k = 0; k < stt_pkg::MASK_W; k++)
        begin : g_mask
            if (k < SLOTS)
            begin : g_live
                assign mask[k] = fire[k];
            end
            else
            begin : g_none
                assign mask[k] = 1'b0;
            end
        end
    endgenerate

    assign free_idx_wide = {3'b000, free_idx};

    assign req_valid_next = accept ? 1'b1 : (advance ? 1'b0 : req_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            command_reg   <= '0;
            slot_reg      <= '0;
            fast_reg      <= 1'b0;
            periodic_reg  <= 1'b0;
            interval_reg  <= '0;
            fire_mask_reg <= '0;
            created_reg   <= 1'b0;
            new_slot_reg  <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                command_reg  <= command;
                slot_reg     <= slot;
                fast_reg     <= fast_source;
                periodic_reg <= periodic;
                interval_reg <= interval;
            end
            if (advance)
            begin
                fire_mask_reg <= mask;
                created_reg   <= is_create && found;
                new_slot_reg  <= (is_create && found) ? free_idx_wide[2:0] : '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign fire_mask = fire_mask_reg;
    assign created   = created_reg;
    assign new_slot  = new_slot_reg;

endmodule

// ----- tb/timer_table_checker.sv -----
// Checker for the software timer table: watches both channels, predicts each result.
// Depends on stt_pkg; instantiated next to the block by the testbench top.
module timer_table_checker
#(
    parameter int TABLE_SLOTS = 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [2:0]                     command,
    input  logic [stt_pkg::SLOT_W-1:0]     slot,
    input  logic                           fast_source,
    input  logic                           periodic,
    input  logic [stt_pkg::INTERVAL_W-1:0] interval,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [stt_pkg::MASK_W-1:0]     fire_mask,
    input  logic                           created,
    input  logic [stt_pkg::SLOT_W-1:0]     new_slot,
    output int                             failures,
    output int                             outstanding
);

    typedef struct packed {
        logic [stt_pkg::MASK_W-1:0] fire;
        logic                       made;
        logic [stt_pkg::SLOT_W-1:0] where;
    } timer_result_t;

    bit                             in_use    [TABLE_SLOTS];
    bit                             on_fast   [TABLE_SLOTS];
    bit                             repeats   [TABLE_SLOTS];
    bit                             alive     [TABLE_SLOTS];
    bit                             armed     [TABLE_SLOTS];
    logic [stt_pkg::INTERVAL_W-1:0] reload    [TABLE_SLOTS];
    logic [stt_pkg::INTERVAL_W-1:0] countdown [TABLE_SLOTS];

    timer_result_t expected_results[$];

    function automatic void clear_slot(input int k);
        in_use[k]    = 1'b0;
        on_fast[k]   = 1'b0;
        repeats[k]   = 1'b0;
        alive[k]     = 1'b0;
        armed[k]     = 1'b0;
        reload[k]    = '0;
        countdown[k] = '0;
    endfunction

    function automatic logic [stt_pkg::MASK_W-1:0] count_down(input bit fast_tick);
        logic [stt_pkg::MASK_W-1:0] expired;
        expired = '0;
        for (int k = 0; k < TABLE_SLOTS; k++)
        begin
            if (in_use[k] && armed[k] && alive[k] && on_fast[k] == fast_tick
                    && reload[k] != '0)
            begin
                countdown[k] = countdown[k] - 1'b1;
                if (countdown[k] == '0)
                begin
                    if (k < stt_pkg::MASK_W)
                        expired[k] = 1'b1;
                    countdown[k] = reload[k];
                    // one-shot slots die after their single expiry
                    if (!repeats[k])
                        alive[k] = 1'b0;
                end
            end
        end
        return expired;
    endfunction

    task automatic predict_result(output timer_result_t res);
        bit addressed;
        bit found;
        res       = '0;
        addressed = (int'(slot) < TABLE_SLOTS) && in_use[slot];
        found     = 1'b0;
        case (command)
            stt_pkg::CMD_FAST_TICK: res.fire = count_down(1'b1);
            stt_pkg::CMD_SLOW_TICK: res.fire = count_down(1'b0);
            stt_pkg::CMD_CREATE:
            begin
                for (int k = 0; k < TABLE_SLOTS; k++)
                begin
                    if (!found && !in_use[k])
                    begin
                        clear_slot(k);
                        in_use[k]  = 1'b1;
                        on_fast[k] = fast_source;
                        repeats[k] = periodic;
                        alive[k]   = 1'b1;
                        reload[k]  = interval;
                        found      = 1'b1;
                        res.made   = 1'b1;
                        res.where  = k[stt_pkg::SLOT_W-1:0];
                    end
                end
            end
            stt_pkg::CMD_START:
            begin
                if (addressed)
                begin
                    armed[slot]     = 1'b1;
                    countdown[slot] = reload[slot];
                end
            end
            stt_pkg::CMD_STOP:
            begin
                if (addressed)
                    armed[slot] = 1'b0;
            end
            stt_pkg::CMD_DESTROY:
            begin
                if (addressed)
                    clear_slot(slot);
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < TABLE_SLOTS; k++)
                clear_slot(k);
            expected_results.delete();
            failures    = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected: %s %h created %b new_slot %0d",
                             $time, "fire_mask", fire_mask, created, new_slot);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (fire_mask !== want.fire)
                    begin
                        $display("%0t: fire_mask expected %h actual %h",
                                 $time, want.fire, fire_mask);
                        failures++;
                    end
                    if (created !== want.made)
                    begin
                        $display("%0t: created expected %b actual %b",
                                 $time, want.made, created);
                        failures++;
                    end
                    if (new_slot !== want.where)
                    begin
                        $display("%0t: new_slot expected %0d actual %0d",
                                 $time, want.where, new_slot);
                        failures++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_result(want);
                expected_results.push_back(want);
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Testbench top for the software timer table: clock, reset, request stimulus, verdict.
// Depends on stt_pkg, software_timer_table and timer_table_checker.
module testbench;

    localparam int TABLE_SLOTS  = 8;
    localparam int RANDOM_ITEMS = 2000;

    // codes outside the command set; the block must ignore them
    localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    logic                           clk         = 1'b0;
    logic                           rst_n       = 1'b0;
    logic                           in_valid    = 1'b0;
    logic                           in_stall;
    logic [2:0]                     command     = '0;
    logic [stt_pkg::SLOT_W-1:0]     slot        = '0;
    logic                           fast_source = 1'b0;
    logic                           periodic    = 1'b0;
    logic [stt_pkg::INTERVAL_W-1:0] interval    = '0;
    logic                           out_valid;
    logic                           out_stall   = 1'b0;
    logic [stt_pkg::MASK_W-1:0]     fire_mask;
    logic                           created;
    logic [stt_pkg::SLOT_W-1:0]     new_slot;
    int                             mismatches;
    int                             pending_results;

    software_timer_table #(.SLOTS(TABLE_SLOTS)) dut (.*);

    timer_table_checker #(.TABLE_SLOTS(TABLE_SLOTS)) table_check
    (
        .*,
        .failures(mismatches),
        .outstanding(pending_results)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic send_request(input logic [2:0] cmd,
                                input logic [stt_pkg::SLOT_W-1:0] idx,
                                input logic fast, input logic per,
                                input logic [stt_pkg::INTERVAL_W-1:0] ivl);
        @(negedge clk);
        in_valid    <= 1'b1;
        command     <= cmd;
        slot        <= idx;
        fast_source <= fast;
        periodic    <= per;
        interval    <= ivl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic pause(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic random_request();
        int                             pick;
        logic [2:0]                     cmd;
        logic [stt_pkg::INTERVAL_W-1:0] ivl;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            cmd = stt_pkg::CMD_FAST_TICK;
        else if (pick < 45)
            cmd = stt_pkg::CMD_SLOW_TICK;
        else if (pick < 60)
            cmd = stt_pkg::CMD_CREATE;
        else if (pick < 75)
            cmd = stt_pkg::CMD_START;
        else if (pick < 84)
            cmd = stt_pkg::CMD_STOP;
        else if (pick < 97)
            cmd = stt_pkg::CMD_DESTROY;
        else if (pick < 99)
            cmd = CMD_UNUSED_LO;
        else
            cmd = CMD_UNUSED_HI;
        // keep most intervals short so slots actually expire
        case ($urandom_range(0, 9))
            0:       ivl = '0;
            1:       ivl = $urandom;
            default: ivl = $urandom_range(1, 6);
        endcase
        send_request(cmd, stt_pkg::SLOT_W'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), ivl);
    endtask

    // receiver stall in stretches of changing density
    initial
    begin
        int mode;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 80))
            begin
                @(negedge clk);
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial
    begin
        #3200000;
        $display("software_timer_table verification failed");
        $finish;
    end

    initial
    begin
        int burst_left;
        burst_left = 0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fast periodic, fast one-shot, slow with zero interval
        send_request(stt_pkg::CMD_CREATE, 3'd0, 1'b1, 1'b1, 32'd1);
        send_request(stt_pkg::CMD_CREATE, 3'd7, 1'b1, 1'b0, 32'd2);
        send_request(stt_pkg::CMD_CREATE, 3'd0, 1'b0, 1'b1, 32'd0);
        send_request(stt_pkg::CMD_START, 3'd0, 1'b0, 1'b0, 32'd0);
        send_request(stt_pkg::CMD_START, 3'd1, 1'b0, 1'b0, 32'd0);
        send_request(stt_pkg::CMD_START, 3'd2, 1'b0, 1'b0, 32'd0);
        send_request(stt_pkg::CMD_FAST_TICK, 3'd0, 1'b0, 1'b0, 32'd0);
        send_request(stt_pkg::CMD_FAST_TICK, 3'd0, 1'b0, 1'b0, 32'd0);
        // restart a dead one-shot, then restart a running slot
        send_request(stt_pkg::CMD_START, 3'd1, 1'b0, 1'b0, 32'd0);
        send_request(stt_pkg::CMD_FAST_TICK, 3'd0, 1'b0, 1'b0, 32'd0);
        send_request(stt_pkg::CMD_START, 3'd0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_request(stt_pkg::CMD_SLOW_TICK, 3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF);
        pause(3);
        send_request(stt_pkg::CMD_STOP, 3'd0, 1'b0, 1'b0, 32'd0);
        send_request(stt_pkg::CMD_FAST_TICK, 3'd0, 1'b0, 1'b0, 32'd0);
        // destroy slot 1, then requests on free slots and with unused codes
        send_request(stt_pkg::CMD_DESTROY, 3'd1, 1'b0, 1'b0, 32'd0);
        send_request(stt_pkg::CMD_START, 3'd1, 1'b0, 1'b0, 32'd0);
        send_request(stt_pkg::CMD_STOP, 3'd5, 1'b0, 1'b0, 32'd0);
        send_request(stt_pkg::CMD_DESTROY, 3'd7, 1'b0, 1'b0, 32'd0);
        send_request(CMD_UNUSED_LO, 3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_request(CMD_UNUSED_HI, 3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF);
        pause(2);
        // fill the table, then one create too many
        repeat (6)
            send_request(stt_pkg::CMD_CREATE, 3'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_request(stt_pkg::CMD_CREATE, 3'd0, 1'b1, 1'b1, 32'd3);
        send_request(stt_pkg::CMD_START, 3'd3, 1'b0, 1'b0, 32'd0);
        send_request(stt_pkg::CMD_SLOW_TICK, 3'd0, 1'b0, 1'b0, 32'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    pause($urandom_range(1, 6));
                burst_left = $urandom_range(1, 24);
            end
            if (n == RANDOM_ITEMS / 2)
            begin
                // hold off until every result is back
                pause(1);
                while (pending_results != 0)
                    @(negedge clk);
            end
            random_request();
            burst_left--;
        end

        pause(1);
        while (pending_results != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
        if (mismatches == 0)
            $display("software_timer_table verification clean");
        else
            $display("software_timer_table verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/stt_pkg.sv
rtl/stt_slot.sv
rtl/stt_alloc.sv
rtl/software_timer_table.sv
tb/timer_table_checker.sv
tb/testbench.sv
